/* src/assert_macros.svh */
// Assertion macros used by the seven_segment_signed_encoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked out of reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

/* src/sseg_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sseg_pkg
// Types, constants and the digit pattern table of the seven-segment encoder.
// ----------------------------------------------------------------------------
package sseg_pkg;

   localparam int ValueWidth = 16;
   localparam int MagWidth   = 14;
   localparam int DigitWidth = 4;
   localparam int SegWidth   = 7;

   localparam logic [MagWidth-1:0] MAG_LIMIT     = 14'd9999;
   localparam logic [SegWidth-1:0] MINUS_PATTERN = 7'h40;

   typedef logic [DigitWidth-1:0] digit_type;
   typedef logic [SegWidth-1:0]   seg_type;

   typedef struct packed {
      logic      negative;
      logic      clamped;
      digit_type thousands;
      digit_type hundreds;
      digit_type tens;
      digit_type units;
   } digits_type;

   typedef struct packed {
      seg_type left;
      seg_type hundreds;
      seg_type tens;
      seg_type units;
      logic    clamped;
   } segs_type;

   // gfedcba, active high
   function automatic seg_type digit_pattern(input digit_type d);
      seg_type p;
      case (d)
         4'd0:    p = 7'h3F;
         4'd1:    p = 7'h06;
         4'd2:    p = 7'h5B;
         4'd3:    p = 7'h4F;
         4'd4:    p = 7'h66;
         4'd5:    p = 7'h6D;
         4'd6:    p = 7'h7D;
         4'd7:    p = 7'h07;
         4'd8:    p = 7'h7F;
         4'd9:    p = 7'h6F;
         default: p = 7'h3F;
      endcase
      return p;
   endfunction

endpackage

/* src/seven_segment_signed_encoder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seven_segment_signed_encoder
// Signed 16-bit value to four seven-segment digit patterns.
// ----------------------------------------------------------------------------
// Usage:
//   Send one signed value per request on the req_ stream. Each request
//   yields exactly one response on the rsp_ stream holding four segment
//   patterns (gfedcba, active high) and a clamp flag. Magnitudes above 9999
//   are clamped to 9999; a negative value shows a minus sign in the leftmost
//   position in place of the thousands digit.
//   Path: an accepted request enters the input register, then the result
//   register, with the digit split and pattern lookup between them.
//   Throughput: one request per cycle while rsp_tready stays high; the
//   single-pass encode logic between the two registers sets this figure.
//   Stall: when rsp_tready is low the result register holds, and the input
//   register still takes one more request; req_tready drops only when both
//   registers are full.
//   Reset: synchronous, active high; clears both valid flags, so the block
//   comes up empty and ready.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module seven_segment_signed_encoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] value
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata    // [6:0] seg_left, [13:7] seg_hundreds,
                                    // [20:14] seg_tens, [27:21] seg_units,
                                    // [28] clamped, [31:29] zero
);
   import sseg_pkg::*;

   logic                  stage_valid_ff;
   logic                  stage_valid_in;
   logic [ValueWidth-1:0] stage_value_ff;
   logic                  stage_ready;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic [31:0]           rsp_data_ff;
   logic                  out_ready;
   digits_type            digits;
   segs_type              segs;

   // Result register is free when empty or being drained this cycle
   assign out_ready   = !rsp_valid_ff || rsp_tready;
   // Input register advances when it is empty or its request moves on
   assign stage_ready = !stage_valid_ff || out_ready;
   assign req_tready  = stage_ready;

   assign stage_valid_in = stage_ready ? req_tvalid : stage_valid_ff;
   assign rsp_valid_in   = out_ready ? stage_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Capture the request value
   always_ff @(posedge clock) begin
      if (stage_ready && req_tvalid) begin
         stage_value_ff <= req_tdata;
      end
   end

   sseg_digits u_digits (
      .value  (stage_value_ff),
      .digits (digits)
   );

   sseg_encode u_encode (
      .digits (digits),
      .segs   (segs)
   );

   // Load the result register; hold it while the receiver stalls
   always_ff @(posedge clock) begin
      if (out_ready && stage_valid_ff) begin
         rsp_data_ff <= {3'b000, segs.clamped, segs.units, segs.tens,
                         segs.hundreds, segs.left};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `ASSERT_NEXT(a_accept_fills_stage, clock, reset, req_tvalid && req_tready, stage_valid_ff)
   `ASSERT_NEXT(a_stage_holds, clock, reset, stage_valid_ff && !stage_ready, stage_valid_ff && $stable(stage_value_ff))
   `ASSERT_NEXT(a_minus_shown, clock, reset, stage_valid_ff && out_ready && stage_value_ff[ValueWidth-1], rsp_tvalid && (rsp_tdata[6:0] == MINUS_PATTERN))
   `ASSERT_IMPL(a_pad_zero, clock, reset, rsp_tvalid, rsp_tdata[31:29] == 3'b000)

endmodule

/* src/sseg_digits.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sseg_digits
// Magnitude, clamp to 9999 and split into four decimal digits.
// ----------------------------------------------------------------------------
module sseg_digits (
   input  logic [sseg_pkg::ValueWidth-1:0] value,
   output sseg_pkg::digits_type            digits
);
   import sseg_pkg::*;

   logic                  negative;
   logic [ValueWidth-1:0] mag_full;
   logic                  over;
   logic [MagWidth-1:0]   mag;
   logic [29:0]           prod10;
   logic [29:0]           prod100;
   logic [29:0]           prod1000;
   logic [9:0]            q10;
   logic [6:0]            q100;
   logic [3:0]            q1000;
   logic [MagWidth-1:0]   r_units;
   logic [9:0]            r_tens;
   logic [6:0]            r_hundreds;

   assign negative = value[ValueWidth-1];
   // -32768 wraps to 0x8000, which reads correctly as an unsigned magnitude
   assign mag_full = negative ? (~value + 16'd1) : value;
   assign over     = mag_full > {2'b00, MAG_LIMIT};
   assign mag      = over ? MAG_LIMIT : mag_full[MagWidth-1:0];

   // Reciprocal multiplies, exact for magnitudes up to 9999
   assign prod10   = {16'd0, mag} * 30'd52429;
   assign prod100  = {16'd0, mag} * 30'd5243;
   assign prod1000 = {16'd0, mag} * 30'd8389;
   assign q10      = prod10[28:19];
   assign q100     = prod100[25:19];
   assign q1000    = prod1000[26:23];

   // Remainders by shift-add times ten
   assign r_units    = mag - ({q10, 3'b000} + {3'b000, q10, 1'b0});
   assign r_tens     = q10 - ({q100, 3'b000} + {2'b00, q100, 1'b0});
   assign r_hundreds = q100 - ({q1000, 3'b000} + {2'b00, q1000, 1'b0});

   assign digits.negative  = negative;
   assign digits.clamped   = over;
   assign digits.thousands = q1000;
   assign digits.hundreds  = r_hundreds[DigitWidth-1:0];
   assign digits.tens      = r_tens[DigitWidth-1:0];
   assign digits.units     = r_units[DigitWidth-1:0];

endmodule

/* src/sseg_encode.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sseg_encode
// Map four decimal digits to segment patterns, minus sign on the left.
// ----------------------------------------------------------------------------
module sseg_encode (
   input  sseg_pkg::digits_type digits,
   output sseg_pkg::segs_type   segs
);
   import sseg_pkg::*;

   assign segs.left     = digits.negative ? MINUS_PATTERN
                                          : digit_pattern(digits.thousands);
   assign segs.hundreds = digit_pattern(digits.hundreds);
   assign segs.tens     = digit_pattern(digits.tens);
   assign segs.units    = digit_pattern(digits.units);
   assign segs.clamped  = digits.clamped;

endmodule

/* sim/seven_segment_signed_encoder_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seven_segment_signed_encoder_test
// Self-checking bench for the signed seven-segment encoder. A directed set
// of boundary values and a large random mix are streamed in. Every accepted
// request is encoded by an independent predictor, and every response is
// compared field by field with the oldest prediction. Both stream sides
// idle at random, and the response side holds off once for a long stretch
// so that the block fills up and stalls its input.
// ----------------------------------------------------------------------------
module seven_segment_signed_encoder_test;
   import sseg_pkg::*;

   localparam int NumRandom   = 1450;
   localparam int IdlePercent = 27;
   localparam int QuietFirst  = 500;   // no idling on either side in this span
   localparam int QuietLast   = 800;
   localparam int HoldAfter   = 400;   // requests seen before the long hold-off
   localparam int HoldCycles  = 150;
   localparam int DrainCycles = 10;
   localparam int StallLimit  = 2000;  // cycles without any handshake
   localparam int ReportLimit = 10;

   // -------------------------------------------------------------------------
   // Predictor and store of expected segment words
   // -------------------------------------------------------------------------
   class segment_scoreboard;
      logic [31:0] expected_q[$];
      int unsigned mismatches;

      function seg_type digit_segments(int unsigned digit);
         case (digit)
            0:       return 7'h3F;
            1:       return 7'h06;
            2:       return 7'h5B;
            3:       return 7'h4F;
            4:       return 7'h66;
            5:       return 7'h6D;
            6:       return 7'h7D;
            7:       return 7'h07;
            8:       return 7'h7F;
            default: return 7'h6F;
         endcase
      endfunction

      function logic [31:0] encode_value(logic [15:0] value);
         logic        negative;
         logic [16:0] magnitude;
         logic        over;
         int unsigned mag;
         seg_type     left;
         negative  = value[15];
         magnitude = negative ? (17'h10000 - {1'b0, value}) : {1'b0, value};
         over      = magnitude > {3'b0, MAG_LIMIT};
         mag       = over ? int'(MAG_LIMIT) : int'(magnitude);
         left      = negative ? MINUS_PATTERN : digit_segments((mag / 1000) % 10);
         return {3'b000, over,
                 digit_segments(mag % 10),
                 digit_segments((mag / 10) % 10),
                 digit_segments((mag / 100) % 10),
                 left};
      endfunction

      function void report(string what);
         mismatches++;
         if (mismatches <= ReportLimit) $display("mismatch: %s", what);
      endfunction

      function void compare_field(string name, logic [6:0] want, logic [6:0] got);
         if (want !== got) report($sformatf("%s expected %h actual %h", name, want, got));
      endfunction

      function void note_value(logic [15:0] value);
         expected_q.push_back(encode_value(value));
      endfunction

      function void check_result(logic [31:0] actual);
         logic [31:0] want;
         if (expected_q.size() == 0) begin
            report($sformatf("unexpected response %h", actual));
            return;
         end
         want = expected_q.pop_front();
         compare_field("seg_left",     want[6:0],   actual[6:0]);
         compare_field("seg_hundreds", want[13:7],  actual[13:7]);
         compare_field("seg_tens",     want[20:14], actual[20:14]);
         compare_field("seg_units",    want[27:21], actual[27:21]);
         compare_field("clamped",      {6'b0, want[28]},    {6'b0, actual[28]});
         compare_field("pad",          {4'b0, want[31:29]}, {4'b0, actual[31:29]});
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Block under test
   // -------------------------------------------------------------------------
   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;    // [15:0] value
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;    // [6:0] seg_left, [13:7] seg_hundreds, [20:14] seg_tens,
                              // [27:21] seg_units, [28] clamped, [31:29] zero

   seven_segment_signed_encoder DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   segment_scoreboard segments = new();
   logic [15:0]       stimulus_q[$];
   int unsigned       request_count = 0;
   int unsigned       quiet_cycles  = 0;
   logic              quiet_phase   = 1'b0;

   // -------------------------------------------------------------------------
   // Monitor: note every accepted request, check every accepted response and
   // count cycles with no handshake for the watchdog. Sampling right after
   // the edge sees the values that were present at the edge.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            segments.note_value(req_tdata);
            request_count <= request_count + 1;
         end
         if (rsp_tvalid && rsp_tready) segments.check_result(rsp_tdata);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= StallLimit) begin
            $display("TB_ERROR");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   // -------------------------------------------------------------------------
   // Stimulus: boundary values first, then a random mix weighted toward the
   // displayable range, with the full 16-bit range and small values mixed in.
   // -------------------------------------------------------------------------
   task automatic build_stimulus();
      int pick;
      // zero, single digits and every place value rollover
      stimulus_q = '{16'd0, 16'd1, 16'd9, 16'd10, 16'd99, 16'd100, 16'd999, 16'd1000};
      // positive and negative values of one to four digits: minus replaces the thousands
      stimulus_q.push_back(16'd1234);
      stimulus_q.push_back(-16'sd1234);
      stimulus_q.push_back(16'd5678);
      stimulus_q.push_back(-16'sd5);
      stimulus_q.push_back(-16'sd1);
      stimulus_q.push_back(-16'sd999);
      stimulus_q.push_back(-16'sd1000);
      // clamp edge on both signs
      stimulus_q.push_back(16'd9999);
      stimulus_q.push_back(-16'sd9999);
      stimulus_q.push_back(16'd10000);
      stimulus_q.push_back(-16'sd10000);
      // extremes, with the most negative value clamping to 9999 and showing minus 999
      stimulus_q.push_back(16'h7FFF);
      stimulus_q.push_back(16'h8000);
      stimulus_q.push_back(16'h5555);
      stimulus_q.push_back(16'hAAAA);
      stimulus_q.push_back(16'hFFFE);
      for (int i = 0; i < NumRandom; i++) begin
         pick = $urandom_range(99);
         if (pick < 45)
            stimulus_q.push_back(16'($urandom_range(19998)) - 16'd9999);
         else if (pick < 80)
            stimulus_q.push_back(16'($urandom));
         else if (pick < 90)
            stimulus_q.push_back(16'($urandom_range(40)) - 16'd20);
         else
            // land near the clamp boundary on either sign
            stimulus_q.push_back(($urandom_range(1) ? 16'd9999 : -16'sd9999)
                                 + 16'($urandom_range(6)) - 16'd3);
      end
   endtask

   // Offer requests with random gaps; hold the current request while stalled.
   task automatic drive_requests();
      int unsigned sent;
      logic        quiet;
      sent = 0;
      while (sent < stimulus_q.size()) begin
         @(posedge clock);
         if (req_tvalid && req_tready) sent++;
         quiet = (sent >= QuietFirst) && (sent < QuietLast);
         quiet_phase <= quiet;
         if (!(req_tvalid && !req_tready)) begin
            if (sent < stimulus_q.size() && (quiet || $urandom_range(99) >= IdlePercent)) begin
               req_tvalid <= 1'b1;
               req_tdata  <= stimulus_q[sent];
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   endtask

   // -------------------------------------------------------------------------
   // Response side: random back-pressure, none during the quiet span, and one
   // long hold-off while the sender keeps offering so the block fills up.
   // -------------------------------------------------------------------------
   initial begin
      bit hold_done;
      hold_done = 1'b0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!hold_done && request_count >= HoldAfter) begin
            rsp_tready <= 1'b0;
            repeat (HoldCycles) @(posedge clock);
            hold_done = 1'b1;
         end else begin
            rsp_tready <= quiet_phase || ($urandom_range(99) >= IdlePercent);
         end
      end
   end

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      build_stimulus();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      drive_requests();
      // let the monitor note the last request before looking at what is open
      @(posedge clock);

      // drain: the watchdog catches a response that never comes
      while (segments.pending() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);

      if (segments.mismatches == 0 && segments.pending() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

/* seven_segment_signed_encoder.f */
+incdir+src
src/sseg_pkg.sv
src/sseg_digits.sv
src/sseg_encode.sv
src/seven_segment_signed_encoder.sv
sim/seven_segment_signed_encoder_test.sv
